/* design/acss_pkg.sv */
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types, widths and codes for the audio clock sync sample adjuster.
// ----------------------------------------------------------------------------
package acss_pkg;

  // fractional bits of the Q.24 time format
  localparam int TIME_FRAC_BITS = 24;

  localparam int RATE_W     = 18;
  localparam int LIMIT_W    = 47;
  localparam int COEF_W     = 16;
  localparam int WARM_W     = 8;
  localparam int TIME_W     = 48;
  localparam int DIFF_W     = TIME_W + 1;
  localparam int N_W        = 16;
  localparam int WANT_W     = 17;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  // shared multiplier: 24 x 20 bits, wide products built from two halves
  localparam int SPLIT_W = 24;
  localparam int MB_W    = 20;
  localparam int PROD_W  = SPLIT_W + MB_W;
  localparam int PACC_W  = 64;
  localparam int SEL_W   = 3;

  localparam int CAP_W = 46;
  localparam logic [CAP_W-1:0] DIFF_CAP = CAP_W'(1) << (CAP_W - 1);
  localparam int S_W = 21;
  localparam logic [S_W-1:0] S_CAP = S_W'(1) << (S_W - 1);

  // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT for x below 2^22
  localparam logic [MB_W-1:0] DIV10_RECIP = 20'd838861;
  localparam int DIV10_SHIFT = 23;
  localparam int NX_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOSYNC_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_COEF        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_FRAMES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_IS_MASTER = 3'd5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_MASTER = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WARM   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_NOCORR = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CORR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd4;

  // multiplier operand A selects
  localparam logic [SEL_W-1:0] MA_ACC_LO = 3'd0;
  localparam logic [SEL_W-1:0] MA_ACC_HI = 3'd1;
  localparam logic [SEL_W-1:0] MA_D_LO   = 3'd2;
  localparam logic [SEL_W-1:0] MA_D_HI   = 3'd3;
  localparam logic [SEL_W-1:0] MA_N9     = 3'd4;
  localparam logic [SEL_W-1:0] MA_N11    = 3'd5;

  // multiplier operand B selects
  localparam logic [1:0] MB_COEF  = 2'd0;
  localparam logic [1:0] MB_COMP  = 2'd1;
  localparam logic [1:0] MB_RATE  = 2'd2;
  localparam logic [1:0] MB_RECIP = 2'd3;

  typedef struct packed {
    logic [RATE_W-1:0]  out_rate;
    logic [LIMIT_W-1:0] nosync_limit;
    logic [COEF_W-1:0]  avg_coef;
    logic [WARM_W-1:0]  warmup_frames;
    logic [LIMIT_W-1:0] diff_threshold;
    logic               audio_is_master;
  } cfg_t;

  typedef struct packed {
    logic             cap_in;
    logic             calc_diff;
    logic             calc_mag;
    logic [SEL_W-1:0] ma_sel;
    logic [1:0]       mb_sel;
    logic             acc_load;
    logic             acc_add;
    logic             calc_term;
    logic             upd_accum;
    logic             frm_inc;
    logic             clr_state;
    logic             calc_s;
    logic             ld_lo;
    logic             ld_hi;
    logic             out_load;
    logic [ACT_W-1:0] act;
  } cmd_t;

  typedef struct packed {
    logic master;
    logic nosync;
    logic warm;
    logic below;
    logic out_full;
  } sts_t;

endpackage

/* design/audio_clock_sync_sample_adjust.sv */
// Takes one item at a time: in_ready is high only in idle, and a new item is
// accepted only after the last result has been loaded into the output register,
// which waits while a held result is not taken. The shared 24x20 multiplier
// builds each wide product in halves.
// Reset (synchronous, rst high) loads the register defaults, clears the
// averaging state and empties the output register.
// ----------------------------------------------------------------------------
// audio_clock_sync_sample_adjust
// Adjusts the per-frame sample count to pull the audio clock onto the master.
// ----------------------------------------------------------------------------
module audio_clock_sync_sample_adjust
  import acss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [N_W-1:0]           frame_samples,
  input  logic signed [TIME_W-1:0] audio_time,
  input  logic signed [TIME_W-1:0] master_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [WANT_W-1:0]        target_samples,
  output logic [ACT_W-1:0]         action
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  acss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  acss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acss_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .frame_samples  (frame_samples),
    .audio_time     (audio_time),
    .master_time    (master_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .target_samples (target_samples),
    .action         (action)
  );

endmodule

/* design/acss_cfg.sv */
// ----------------------------------------------------------------------------
// acss_cfg
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module acss_cfg
  import acss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_rate        <= RATE_W'(48000);
      cfg.nosync_limit    <= LIMIT_W'(167772160);
      cfg.avg_coef        <= COEF_W'(52035);
      cfg.warmup_frames   <= WARM_W'(20);
      cfg.diff_threshold  <= LIMIT_W'(838861);
      cfg.audio_is_master <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUT_RATE:        cfg.out_rate        <= cfg_data[RATE_W-1:0];
        REG_NOSYNC_LIMIT:    cfg.nosync_limit    <= cfg_data[LIMIT_W-1:0];
        REG_AVG_COEF:        cfg.avg_coef        <= cfg_data[COEF_W-1:0];
        REG_WARMUP_FRAMES:   cfg.warmup_frames   <= cfg_data[WARM_W-1:0];
        REG_DIFF_THRESHOLD:  cfg.diff_threshold  <= cfg_data[LIMIT_W-1:0];
        REG_AUDIO_IS_MASTER: cfg.audio_is_master <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* design/acss_ctrl.sv */
// ----------------------------------------------------------------------------
// acss_ctrl
// Sequencer: steps the datapath through difference, averaging and
// correction, and picks the action code.
// ----------------------------------------------------------------------------
module acss_ctrl
  import acss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DIFF  = 5'd1;
  localparam logic [4:0] S_MAG   = 5'd2;
  localparam logic [4:0] S_CHECK = 5'd3;
  localparam logic [4:0] S_T0    = 5'd4;
  localparam logic [4:0] S_T1    = 5'd5;
  localparam logic [4:0] S_T2    = 5'd6;
  localparam logic [4:0] S_TERM  = 5'd7;
  localparam logic [4:0] S_SUM   = 5'd8;
  localparam logic [4:0] S_AMAG  = 5'd9;
  localparam logic [4:0] S_A0    = 5'd10;
  localparam logic [4:0] S_A1    = 5'd11;
  localparam logic [4:0] S_A2    = 5'd12;
  localparam logic [4:0] S_ACMP  = 5'd13;
  localparam logic [4:0] S_S0    = 5'd14;
  localparam logic [4:0] S_S1    = 5'd15;
  localparam logic [4:0] S_S2    = 5'd16;
  localparam logic [4:0] S_S3    = 5'd17;
  localparam logic [4:0] S_S4    = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  logic [4:0]       state, state_next;
  logic [ACT_W-1:0] act, act_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_MASTER;
    end else begin
      state <= state_next;
      act   <= act_next;
    end
  end

  always_comb begin
    state_next = state;
    act_next   = act;
    cmd        = '0;
    cmd.act    = act;
    cmd.ma_sel = MA_ACC_LO;
    cmd.mb_sel = MB_COEF;
    case (state)
      S_IDLE: begin
        cmd.cap_in = in_valid;
        if (in_valid) state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        if (sts.master) begin
          act_next   = ACT_MASTER;
          state_next = S_FIN;
        end else begin
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.calc_mag = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (sts.nosync) begin
          cmd.clr_state = 1'b1;
          act_next      = ACT_RESET;
          state_next    = S_FIN;
        end else begin
          state_next = S_T0;
        end
      end
      // accum * coef, low half then high half
      S_T0: begin
        cmd.ma_sel = MA_ACC_LO;
        state_next = S_T1;
      end
      S_T1: begin
        cmd.ma_sel   = MA_ACC_HI;
        cmd.acc_load = 1'b1;
        state_next   = S_T2;
      end
      S_T2: begin
        cmd.acc_add = 1'b1;
        state_next  = S_TERM;
      end
      S_TERM: begin
        cmd.calc_term = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        cmd.upd_accum = 1'b1;
        if (sts.warm) begin
          cmd.frm_inc = 1'b1;
          act_next    = ACT_WARM;
          state_next  = S_FIN;
        end else begin
          state_next = S_AMAG;
        end
      end
      S_AMAG: begin
        cmd.calc_mag = 1'b1;
        state_next   = S_A0;
      end
      // |accum| * (1 - coef)
      S_A0: begin
        cmd.ma_sel = MA_ACC_LO;
        cmd.mb_sel = MB_COMP;
        state_next = S_A1;
      end
      S_A1: begin
        cmd.ma_sel   = MA_ACC_HI;
        cmd.mb_sel   = MB_COMP;
        cmd.acc_load = 1'b1;
        state_next   = S_A2;
      end
      S_A2: begin
        cmd.acc_add = 1'b1;
        state_next  = S_ACMP;
      end
      S_ACMP: begin
        if (sts.below) begin
          act_next   = ACT_NOCORR;
          state_next = S_FIN;
        end else begin
          state_next = S_S0;
        end
      end
      // |d| * output rate, then the 90 and 110 percent bounds
      S_S0: begin
        cmd.ma_sel = MA_D_LO;
        cmd.mb_sel = MB_RATE;
        state_next = S_S1;
      end
      S_S1: begin
        cmd.ma_sel   = MA_D_HI;
        cmd.mb_sel   = MB_RATE;
        cmd.acc_load = 1'b1;
        state_next   = S_S2;
      end
      S_S2: begin
        cmd.ma_sel  = MA_N9;
        cmd.mb_sel  = MB_RECIP;
        cmd.acc_add = 1'b1;
        state_next  = S_S3;
      end
      S_S3: begin
        cmd.ma_sel = MA_N11;
        cmd.mb_sel = MB_RECIP;
        cmd.calc_s = 1'b1;
        cmd.ld_lo  = 1'b1;
        state_next = S_S4;
      end
      S_S4: begin
        cmd.ld_hi  = 1'b1;
        act_next   = ACT_CORR;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/acss_dp.sv */
// ----------------------------------------------------------------------------
// acss_dp
// Datapath: difference, shared 24x20 multiplier with product accumulator,
// averaging state, correction clamp and output register.
// ----------------------------------------------------------------------------
module acss_dp
  import acss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [N_W-1:0]           frame_samples,
  input  logic signed [TIME_W-1:0] audio_time,
  input  logic signed [TIME_W-1:0] master_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [WANT_W-1:0]        target_samples,
  output logic [ACT_W-1:0]         action
);

  logic [N_W-1:0]           n;
  logic signed [TIME_W-1:0] at, mt;
  logic signed [DIFF_W-1:0] d;
  logic [DIFF_W-1:0]        dmag;
  logic [TIME_W-1:0]        accmag;
  logic                     neg_flag;
  logic signed [TIME_W-1:0] accum;
  logic [WARM_W-1:0]        frames_seen;
  logic [PROD_W-1:0]        preg;
  logic [PACC_W-1:0]        pacc;
  logic signed [DIFF_W-1:0] term;
  logic [S_W-1:0]           sreg;
  logic [WANT_W-1:0]        lo, hi;

  logic [CAP_W-1:0]         dcap;
  logic [NX_W-1:0]          n9, n11;
  logic [SPLIT_W-1:0]       mul_a;
  logic [MB_W-1:0]          mul_b;
  logic signed [PACC_W-1:0] pacc_s;
  logic signed [DIFF_W:0]   sum;
  logic signed [TIME_W-1:0] sum_sat;
  logic [PACC_W-TIME_FRAC_BITS-1:0] s_full;
  logic signed [S_W:0]      wraw;
  logic [WANT_W-1:0]        wclamp;

  assign dcap = (dmag > DIFF_W'(DIFF_CAP)) ? DIFF_CAP : dmag[CAP_W-1:0];
  assign n9   = NX_W'({n, 3'b000}) + NX_W'(n);
  assign n11  = NX_W'({n, 3'b000}) + NX_W'({n, 1'b0}) + NX_W'(n);

  always_comb begin
    case (cmd.ma_sel)
      MA_ACC_LO: mul_a = accmag[SPLIT_W-1:0];
      MA_ACC_HI: mul_a = accmag[TIME_W-1:SPLIT_W];
      MA_D_LO:   mul_a = dcap[SPLIT_W-1:0];
      MA_D_HI:   mul_a = SPLIT_W'(dcap[CAP_W-1:SPLIT_W]);
      MA_N9:     mul_a = SPLIT_W'(n9);
      MA_N11:    mul_a = SPLIT_W'(n11);
      default:   mul_a = '0;
    endcase
    case (cmd.mb_sel)
      MB_COEF:  mul_b = MB_W'(cfg.avg_coef);
      MB_COMP:  mul_b = MB_W'(17'h10000 - {1'b0, cfg.avg_coef});
      MB_RATE:  mul_b = MB_W'(cfg.out_rate);
      MB_RECIP: mul_b = DIV10_RECIP;
      default:  mul_b = '0;
    endcase
  end

  function automatic logic signed [PACC_W-1:0] term_neg_sel(
    input logic [TIME_W-1:0] mag, input logic [PACC_W-1:0] p);
    logic signed [PACC_W-1:0] r;
    r = $signed(p);
    if (mag != '0 && neg_flag) r = -$signed(p);
    return r;
  endfunction

  // negative accumulator: floor of -|p| / 2^16 is an arithmetic shift of -|p|
  assign pacc_s = term_neg_sel(accmag, pacc);

  assign sum = {d[DIFF_W-1], d} + {term[DIFF_W-1], term};
  always_comb begin
    if (sum[DIFF_W] == sum[DIFF_W-1] && sum[DIFF_W-1] == sum[TIME_W-1])
      sum_sat = sum[TIME_W-1:0];
    else if (sum[DIFF_W])
      sum_sat = {1'b1, {(TIME_W-1){1'b0}}};
    else
      sum_sat = {1'b0, {(TIME_W-1){1'b1}}};
  end

  assign s_full = pacc[PACC_W-1:TIME_FRAC_BITS];

  assign wraw = d[DIFF_W-1] ? ($signed((S_W+1)'(n)) - $signed({1'b0, sreg}))
                            : ($signed((S_W+1)'(n)) + $signed({1'b0, sreg}));
  always_comb begin
    if (wraw < $signed((S_W+1)'(lo)))
      wclamp = lo;
    else if (wraw > $signed((S_W+1)'(hi)))
      wclamp = hi;
    else
      wclamp = wraw[WANT_W-1:0];
  end

  assign sts.master   = cfg.audio_is_master;
  assign sts.nosync   = dmag >= DIFF_W'(cfg.nosync_limit);
  assign sts.warm     = frames_seen < cfg.warmup_frames;
  assign sts.below    = pacc[PACC_W-1:16] < TIME_W'(cfg.diff_threshold);
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      n  <= frame_samples;
      at <= audio_time;
      mt <= master_time;
    end
    if (cmd.calc_diff) d <= DIFF_W'(at) - DIFF_W'(mt);
    if (cmd.calc_mag) begin
      dmag     <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      accmag   <= accum[TIME_W-1] ? TIME_W'(-accum) : TIME_W'(accum);
      neg_flag <= accum[TIME_W-1];
    end
    preg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.acc_load)
      pacc <= PACC_W'(preg);
    else if (cmd.acc_add)
      pacc <= pacc + (PACC_W'(preg) << SPLIT_W);
    if (cmd.calc_term) term <= DIFF_W'(pacc_s >>> 16);
    if (cmd.calc_s)
      sreg <= (s_full > (PACC_W-TIME_FRAC_BITS)'(S_CAP)) ? S_CAP : s_full[S_W-1:0];
    if (cmd.ld_lo) lo <= preg[DIV10_SHIFT +: WANT_W];
    if (cmd.ld_hi) hi <= preg[DIV10_SHIFT +: WANT_W];
  end

  // averaging state
  always_ff @(posedge clk) begin
    if (rst) begin
      accum       <= '0;
      frames_seen <= '0;
    end else if (cmd.clr_state) begin
      accum       <= '0;
      frames_seen <= '0;
    end else begin
      if (cmd.upd_accum) accum <= sum_sat;
      if (cmd.frm_inc)   frames_seen <= frames_seen + WARM_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      target_samples <= (cmd.act == ACT_CORR) ? wclamp : WANT_W'(n);
      action         <= cmd.act;
    end
  end

endmodule

/* design/acss_chk.sv */
// ----------------------------------------------------------------------------
// acss_chk
// Port-level checks for the sample adjuster, bound to the top level.
// ----------------------------------------------------------------------------
module acss_chk
  import acss_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [WANT_W-1:0]        target_samples,
  input logic [ACT_W-1:0]         action
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_samples) && $stable(action))
    else $error("result changed while stalled");

  // one item in flight: no new item in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

  // only a correction may move the count past the 16-bit frame range
  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != ACT_CORR |-> target_samples[WANT_W-1] == 1'b0)
    else $error("uncorrected count out of range");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind audio_clock_sync_sample_adjust acss_chk u_acss_chk (.*);
